// ===== design/afdp_pkg.sv =====
// Shared constants and types for the ASCII frame decimal field parser.
package afdp_pkg;

    localparam int MAX_FRAME_DEF  = 32;
    localparam int NUM_FIELDS_DEF = 4;
    localparam int NUM_VALUES     = 4;
    localparam int BYTE_W         = 8;
    localparam int FIELDS_W       = 3;

    localparam logic [BYTE_W-1:0] CH_T    = 8'h54;
    localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_TWO  = 8'h32;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_beat_t;

    typedef struct packed {
        logic [NUM_VALUES-1:0][BYTE_W-1:0] values;
        logic [FIELDS_W-1:0]               fields;
        logic                              overflow;
    } result_t;

endpackage

// ===== design/afdp_byte_if.sv =====
// Byte channel interface: valid/ready handshake with one received byte.
interface afdp_byte_if;
    import afdp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/afdp_result_if.sv =====
// Result channel interface: valid/ready handshake with the committed frame values.
interface afdp_result_if;
    import afdp_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   value_zero;
    logic [BYTE_W-1:0]   value_one;
    logic [BYTE_W-1:0]   value_two;
    logic [BYTE_W-1:0]   value_three;
    logic [FIELDS_W-1:0] fields_in_frame;
    logic                field_overflow;

    modport source (
        output valid, output value_zero, output value_one, output value_two,
        output value_three, output fields_in_frame, output field_overflow,
        input ready
    );
    modport sink (
        input valid, input value_zero, input value_one, input value_two,
        input value_three, input fields_in_frame, input field_overflow,
        output ready
    );
endinterface

// ===== design/afdp_byte_reg.sv =====
// Input register: captures one received byte per beat.
module afdp_byte_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    afdp_byte_if.sink            rx,
    input  logic                 advance,
    output afdp_pkg::byte_beat_t beat
);
    import afdp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    assign rx.ready = !valid_reg || advance;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

// ===== design/afdp_parser.sv =====
// Frame parser: per-byte state update, field staging and commit.
module afdp_parser #(
    parameter int MAX_FRAME  = afdp_pkg::MAX_FRAME_DEF,
    parameter int NUM_FIELDS = afdp_pkg::NUM_FIELDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [afdp_pkg::BYTE_W-1:0] data,
    output logic                     produced,
    output afdp_pkg::result_t        result
);
    import afdp_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int IW = $clog2(NUM_FIELDS + 1);

    logic              open_reg,  open_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0] hdr_first_reg, hdr_first_next;
    logic [BYTE_W-1:0] hdr_second_reg, hdr_second_next;
    logic [BYTE_W-1:0] acc_reg,   acc_next;
    logic [IW-1:0]     idx_reg,   idx_next;
    logic              ovf_reg,   ovf_next;
    logic [NUM_FIELDS-1:0][BYTE_W-1:0] staged_reg;
    logic [NUM_FIELDS-1:0][BYTE_W-1:0] committed_reg;

    logic              stage_wr;
    logic              emit;
    logic              is_digit;
    logic [BYTE_W-1:0] acc_digit;

    assign is_digit  = (data >= CH_ZERO) && (data <= CH_NINE);
    assign acc_digit = acc_reg * 8'd10 + {4'h0, data[3:0]};

    always_comb
    begin
        open_next       = open_reg;
        count_next      = count_reg;
        hdr_first_next  = hdr_first_reg;
        hdr_second_next = hdr_second_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        ovf_next        = ovf_reg;
        stage_wr        = 1'b0;
        emit            = 1'b0;
        if (step)
        begin
            if (open_reg)
            begin
                if (count_reg == CW'(MAX_FRAME))
                begin
                    // drop the long frame
                    ovf_next   = 1'b1;
                    open_next  = 1'b0;
                    count_next = '0;
                    idx_next   = '0;
                    acc_next   = '0;
                end
                else
                begin
                    if (count_reg == CW'(0))
                    begin
                        hdr_first_next = data;
                    end
                    if (count_reg == CW'(1))
                    begin
                        hdr_second_next = data;
                    end
                    count_next = count_reg + CW'(1);
                    if (count_reg == CW'(2) &&
                        (hdr_first_reg != CH_TWO || hdr_second_reg != CH_ZERO))
                    begin
                        // drop on bad header
                        open_next  = 1'b0;
                        count_next = '0;
                        idx_next   = '0;
                        acc_next   = '0;
                    end
                    else if (data == CH_T)
                    begin
                        emit       = 1'b1;
                        ovf_next   = 1'b0;
                        open_next  = 1'b0;
                        count_next = '0;
                        idx_next   = '0;
                        acc_next   = '0;
                    end
                    else if (data == CH_NL)
                    begin
                        if (idx_reg < IW'(NUM_FIELDS))
                        begin
                            stage_wr = 1'b1;
                            idx_next = idx_reg + IW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        acc_next = '0;
                    end
                    else if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                end
            end
            if (data == CH_A && !open_next)
            begin
                open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            count_reg      <= '0;
            hdr_first_reg  <= '0;
            hdr_second_reg <= '0;
            acc_reg        <= '0;
            idx_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            open_reg       <= open_next;
            count_reg      <= count_next;
            hdr_first_reg  <= hdr_first_next;
            hdr_second_reg <= hdr_second_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            ovf_reg        <= ovf_next;
        end
    end

    for (genvar k = 0; k < NUM_FIELDS; k++)
    begin : g_field
        always_ff @(posedge clk)
        begin
            if (stage_wr && idx_reg == IW'(k))
            begin
                staged_reg[k] <= acc_reg;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                committed_reg[k] <= '0;
            end
            else if (emit && IW'(k) < idx_reg)
            begin
                committed_reg[k] <= staged_reg[k];
            end
        end
    end

    for (genvar k = 0; k < NUM_VALUES; k++)
    begin : g_value
        if (k < NUM_FIELDS)
        begin : g_live
            assign result.values[k] = (IW'(k) < idx_reg) ? staged_reg[k] : committed_reg[k];
        end
        else
        begin : g_absent
            assign result.values[k] = '0;
        end
    end

    assign result.fields   = FIELDS_W'(idx_reg);
    assign result.overflow = ovf_reg;
    assign produced        = emit;

endmodule

// ===== design/afdp_result_reg.sv =====
// Result register: holds one finished frame result until it is taken.
module afdp_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  afdp_pkg::result_t result,
    output logic              can_take,
    afdp_result_if.source     frame
);
    import afdp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_take = !valid_reg || frame.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_take)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && load)
        begin
            data_reg <= result;
        end
    end

    assign frame.valid           = valid_reg;
    assign frame.value_zero      = data_reg.values[0];
    assign frame.value_one       = data_reg.values[1];
    assign frame.value_two       = data_reg.values[2];
    assign frame.value_three     = data_reg.values[3];
    assign frame.fields_in_frame = data_reg.fields;
    assign frame.field_overflow  = data_reg.overflow;

endmodule

// ===== design/ascii_frame_decimal_field_parser.sv =====
// Top level of the ASCII frame decimal field parser.
// Accepts one received byte per cycle on rx and emits one result beat on frame for
// each frame opened by 'A' and closed by 'T' that is not dropped for a header other
// than "20" or for length; NUL bytes are skipped. A byte is held in the input
// register and is parsed on its way into the result register, so a result is loaded
// into the result register as its 'T' leaves the input register; the parser updates
// its state for every byte, which sets the rate of one byte per clock. rx stalls
// only while a result is held in the result register and frame is not ready.
// fields_in_frame counts the newline-ended fields of the frame; field_overflow flags
// a long frame or extra fields since the previous result.
module ascii_frame_decimal_field_parser #(
    parameter int MAX_FRAME  = afdp_pkg::MAX_FRAME_DEF,
    parameter int NUM_FIELDS = afdp_pkg::NUM_FIELDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    afdp_byte_if.sink     rx,
    afdp_result_if.source frame
);
    import afdp_pkg::*;

    byte_beat_t beat;
    result_t    result;
    logic       advance;
    logic       can_take;
    logic       produced;

    assign advance = beat.valid && can_take;

    afdp_byte_reg u_byte_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .beat    (beat)
    );

    afdp_parser #(
        .MAX_FRAME  (MAX_FRAME),
        .NUM_FIELDS (NUM_FIELDS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance && beat.data != CH_NUL),
        .data     (beat.data),
        .produced (produced),
        .result   (result)
    );

    afdp_result_reg u_result_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && produced),
        .result   (result),
        .can_take (can_take),
        .frame    (frame)
    );

endmodule

// ===== design/afdp_checker.sv =====
// Port-level checker for the ASCII frame decimal field parser, bound to the top level.
module afdp_checker #(
    parameter int NUM_FIELDS = afdp_pkg::NUM_FIELDS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rx_valid,
    input logic                          rx_ready,
    input logic [afdp_pkg::BYTE_W-1:0]   rx_byte,
    input logic                          fr_valid,
    input logic                          fr_ready,
    input logic [afdp_pkg::BYTE_W-1:0]   value_zero,
    input logic [afdp_pkg::BYTE_W-1:0]   value_one,
    input logic [afdp_pkg::BYTE_W-1:0]   value_two,
    input logic [afdp_pkg::BYTE_W-1:0]   value_three,
    input logic [afdp_pkg::FIELDS_W-1:0] fields_in_frame,
    input logic                          field_overflow
);
    import afdp_pkg::*;

    // hold a stalled result beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid && !fr_ready |=> fr_valid && $stable(value_zero) && $stable(value_one)
            && $stable(value_two) && $stable(value_three)
            && $stable(fields_in_frame) && $stable(field_overflow))
        else $error("result beat changed while stalled");

    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid |-> (NUM_FIELDS > 7) || (int'(fields_in_frame) <= NUM_FIELDS))
        else $error("field count above configured field limit");

    // a fresh result must follow an accepted 'T' beat
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fr_valid) |-> $past(rx_valid && rx_ready && rx_byte == CH_T, 2))
        else $error("result without a closing T beat");

    // a NUL beat never produces a result
    a_nul_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fr_valid) |-> $past(rx_byte, 2) != CH_NUL)
        else $error("result caused by a NUL beat");

endmodule

bind ascii_frame_decimal_field_parser afdp_checker #(
    .NUM_FIELDS (NUM_FIELDS)
) u_afdp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_valid        (rx.valid),
    .rx_ready        (rx.ready),
    .rx_byte         (rx.rx_byte),
    .fr_valid        (frame.valid),
    .fr_ready        (frame.ready),
    .value_zero      (frame.value_zero),
    .value_one       (frame.value_one),
    .value_two       (frame.value_two),
    .value_three     (frame.value_three),
    .fields_in_frame (frame.fields_in_frame),
    .field_overflow  (frame.field_overflow)
);

// ===== verif/tb_top.sv =====
// Testbench for the ASCII frame decimal field parser: byte stimulus, frame prediction, result check.
module tb_top;
    import afdp_pkg::*;

    localparam int MAX_FRAME    = MAX_FRAME_DEF;
    localparam int NUM_FIELDS   = NUM_FIELDS_DEF;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    class frame_scoreboard;
        bit                open_flag;
        int                stored;
        logic [BYTE_W-1:0] hdr_first;
        logic [BYTE_W-1:0] hdr_second;
        logic [BYTE_W-1:0] acc;
        int                field_idx;
        bit                ovf_flag;
        logic [BYTE_W-1:0] staged [NUM_FIELDS];
        logic [BYTE_W-1:0] committed [NUM_FIELDS];
        result_t           expected_frames [$];
        int                errors;

        function new();
            open_flag  = 1'b0;
            stored     = 0;
            hdr_first  = '0;
            hdr_second = '0;
            acc        = '0;
            field_idx  = 0;
            ovf_flag   = 1'b0;
            errors     = 0;
            foreach (committed[k])
            begin
                committed[k] = '0;
                staged[k]    = '0;
            end
        endfunction

        function void close_frame();
            open_flag = 1'b0;
            stored    = 0;
            field_idx = 0;
            acc       = '0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            result_t     r;
            int          n;
            logic [31:0] sum;
            if (b == CH_NUL)
            begin
                return;
            end
            if (open_flag)
            begin
                if (stored >= MAX_FRAME)
                begin
                    ovf_flag = 1'b1;
                    close_frame();
                end
                else
                begin
                    if (stored == 0)
                    begin
                        hdr_first = b;
                    end
                    else if (stored == 1)
                    begin
                        hdr_second = b;
                    end
                    stored++;
                    if (stored == 3 && (hdr_first != CH_TWO || hdr_second != CH_ZERO))
                    begin
                        close_frame();
                    end
                    else if (b == CH_T)
                    begin
                        n = (field_idx < NUM_FIELDS) ? field_idx : NUM_FIELDS;
                        for (int k = 0; k < n; k++)
                        begin
                            committed[k] = staged[k];
                        end
                        for (int k = 0; k < NUM_VALUES; k++)
                        begin
                            if (k < NUM_FIELDS)
                            begin
                                r.values[k] = committed[k];
                            end
                            else
                            begin
                                r.values[k] = '0;
                            end
                        end
                        r.fields   = n[FIELDS_W-1:0];
                        r.overflow = ovf_flag;
                        ovf_flag   = 1'b0;
                        expected_frames.push_back(r);
                        close_frame();
                    end
                    else if (b == CH_NL)
                    begin
                        if (field_idx < NUM_FIELDS)
                        begin
                            staged[field_idx] = acc;
                            field_idx++;
                        end
                        else
                        begin
                            ovf_flag = 1'b1;
                        end
                        acc = '0;
                    end
                    else if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        sum = acc * 10 + (b - CH_ZERO);
                        acc = sum[BYTE_W-1:0];
                    end
                end
            end
            if (b == CH_A && !open_flag)
            begin
                open_flag = 1'b1;
            end
        endfunction

        function void check_frame(result_t got);
            result_t want;
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual values %h fields %0d ovf %0b",
                         $time, got.values, got.fields, got.overflow);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                if (got.values[k] !== want.values[k])
                begin
                    $display("%0t: value %0d mismatch: expected %0d actual %0d",
                             $time, k, want.values[k], got.values[k]);
                    errors++;
                end
            end
            if (got.fields !== want.fields)
            begin
                $display("%0t: fields_in_frame mismatch: expected %0d actual %0d",
                         $time, want.fields, got.fields);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $display("%0t: field_overflow mismatch: expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    afdp_byte_if   rx_if ();
    afdp_result_if res_if ();

    ascii_frame_decimal_field_parser u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (res_if)
    );

    frame_scoreboard sb = new();

    bit idling_on  = 1'b0;
    int hold_left  = 0;
    int sent_items = 0;

    logic [BYTE_W-1:0] directed_bytes [24] = '{
        CH_T, CH_NUL, CH_A, CH_T, CH_A, CH_TWO, CH_T,
        CH_A, "1", CH_ZERO, CH_A, CH_TWO, CH_ZERO, "9", "9", "9",
        CH_NL, CH_NL, CH_A, CH_NL, CH_NL, CH_NL, "7", CH_T
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [BYTE_W-1:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_byte(logic [BYTE_W-1:0] b);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        sb.note_byte(b);
        if (b != CH_NUL)
        begin
            sent_items++;
        end
    endtask

    task automatic send_good_frame();
        int nf;
        send_byte(CH_A);
        send_byte(CH_TWO);
        send_byte(CH_ZERO);
        nf = $urandom_range(0, 6);
        repeat (nf)
        begin
            repeat ($urandom_range(0, 4))
            begin
                send_byte(rand_digit());
                if ($urandom_range(0, 19) == 0)
                begin
                    send_byte(CH_NUL);
                end
            end
            if ($urandom_range(0, 15) == 0)
            begin
                send_byte(8'($urandom_range(1, 255)));
            end
            send_byte(CH_NL);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_byte(rand_digit());
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_byte(CH_T);
        end
    endtask

    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            send_good_frame();
        end
        else if (pick < 80)
        begin
            send_byte(CH_A);
            send_byte($urandom_range(0, 1) ? CH_TWO : 8'($urandom_range(1, 255)));
            send_byte($urandom_range(0, 1) ? CH_ZERO : 8'($urandom_range(1, 255)));
            send_byte($urandom_range(0, 3) == 0 ? CH_A : rand_digit());
            send_byte(CH_NL);
            send_byte(CH_T);
        end
        else if (pick < 88)
        begin
            send_byte(CH_A);
            send_byte(CH_TWO);
            send_byte(CH_ZERO);
            repeat (MAX_FRAME - 2)
            begin
                send_byte($urandom_range(0, 3) == 0 ? CH_NL : rand_digit());
            end
            if ($urandom_range(0, 1))
            begin
                send_byte(CH_A);
                send_byte(CH_TWO);
                send_byte(CH_ZERO);
                send_byte(rand_digit());
                send_byte(CH_NL);
                send_byte(CH_T);
            end
            else
            begin
                send_byte(rand_digit());
                send_byte(CH_T);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random(int count);
        int start;
        start = sent_items;
        while (sent_items - start < count)
        begin
            send_random_frame();
        end
    endtask

    task automatic wait_drain();
        rx_if.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side: check each beat, then pick the next ready level
    initial
    begin
        int      burst;
        bit      level;
        result_t got;
        burst = 0;
        level = 1'b1;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                got.values[0] = res_if.value_zero;
                got.values[1] = res_if.value_one;
                got.values[2] = res_if.value_two;
                got.values[3] = res_if.value_three;
                got.fields    = res_if.fields_in_frame;
                got.overflow  = res_if.field_overflow;
                sb.check_frame(got);
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (burst == 0)
                begin
                    level = !idling_on || ($urandom_range(0, 3) != 0);
                    burst = $urandom_range(1, 19);
                end
                res_if.ready <= level;
                burst--;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
        begin
            send_byte(directed_bytes[i]);
        end
        wait_drain();

        idling_on = 1'b1;
        run_random(900);

        // hold the result side off while bytes keep coming
        idling_on = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (12) send_good_frame();
        wait_drain();

        idling_on = 1'b1;
        run_random(550);

        idling_on = 1'b0;
        run_random(250);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
